// ----- design/etfi_pkg.sv -----
// Shared types and constants of the escape-time fractal iterator.
`timescale 1ns / 1ps
`default_nettype none
package etfi_pkg;
	localparam int PIX_BITS      = 12;
	localparam int ITER_BITS     = 16;
	localparam int NORM_BITS     = 48;
	localparam int NORM_FRAC     = 24;
	localparam int ESC_BITS      = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ESC_NORM = 1'd1;

	localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = 16'd256;
	localparam logic [ESC_BITS-1:0]  ESC_NORM_RESET = 32'h0400_0000;

	typedef struct packed {
		logic                 load;
		logic                 mul;
		logic                 eval;
		logic                 out_load;
		logic                 out_inside;
		logic [ITER_BITS-1:0] out_count;
	} etfi_cmd_t;

	typedef struct packed {
		logic escape;
	} etfi_status_t;
endpackage
`default_nettype wire

// ----- design/etfi_ifs.sv -----
// Valid/ready channel interfaces for pixel jobs and results.
`timescale 1ns / 1ps
`default_nettype none
interface etfi_job_if #(
	parameter int COORD_BITS = 32
);
	logic                               valid;
	logic                               ready;
	logic signed [COORD_BITS-1:0]       start_re;
	logic signed [COORD_BITS-1:0]       start_im;
	logic signed [COORD_BITS-1:0]       const_re;
	logic signed [COORD_BITS-1:0]       const_im;
	logic [etfi_pkg::PIX_BITS-1:0]      pixel_col;
	logic [etfi_pkg::PIX_BITS-1:0]      pixel_row;

	modport source (output valid, start_re, start_im, const_re, const_im, pixel_col,
		pixel_row, input ready);
	modport sink (input valid, start_re, start_im, const_re, const_im, pixel_col,
		pixel_row, output ready);
endinterface

interface etfi_res_if;
	logic                               valid;
	logic                               ready;
	logic [etfi_pkg::PIX_BITS-1:0]      out_col;
	logic [etfi_pkg::PIX_BITS-1:0]      out_row;
	logic                               inside_res;
	logic [etfi_pkg::ITER_BITS-1:0]     escape_count;
	logic [etfi_pkg::NORM_BITS-1:0]     final_norm;

	modport source (output valid, out_col, out_row, inside_res, escape_count, final_norm,
		input ready);
	modport sink (input valid, out_col, out_row, inside_res, escape_count, final_norm,
		output ready);
endinterface
`default_nettype wire

// ----- design/escape_time_fractal_iterator.sv -----
// Escape-time fractal iterator: z = z*z + c until escape or iteration limit.
// Each iteration is a multiply state and an evaluate state through the three product
// registers; escape_count is max_iterations when the point stays inside.
// Throughput: one job at a time, next request taken the cycle after the result is
// registered; a result waiting in the output register does not block intake.
// Reset: arst_n clears control and sets max_iterations=256, escape_norm=4.0 (Q8.24).
`timescale 1ns / 1ps
`default_nettype none
module escape_time_fractal_iterator #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 28
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [etfi_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  wire [etfi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	etfi_job_if.sink                            job,
	etfi_res_if.source                          res
);
	import etfi_pkg::*;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	logic [ITER_BITS-1:0] max_iter_q;
	logic [ESC_BITS-1:0]  esc_norm_q;

	etfi_cmd_t    cmd;
	etfi_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
			esc_norm_q <= ESC_NORM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_ITER: max_iter_q <= cfg_data[ITER_BITS-1:0];
				REG_ESC_NORM: esc_norm_q <= cfg_data[ESC_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: owns the request handshakes and the iteration count
	etfi_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (job.valid),
		.in_ready       (job.ready),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.max_iterations (max_iter_q),
		.status         (status),
		.cmd            (cmd)
	);

	// datapath: z, c, products, norm and the result register
	etfi_datapath #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.start_re     (job.start_re),
		.start_im     (job.start_im),
		.const_re     (job.const_re),
		.const_im     (job.const_im),
		.pixel_col    (job.pixel_col),
		.pixel_row    (job.pixel_row),
		.escape_norm  (esc_norm_q),
		.status       (status),
		.out_col      (res.out_col),
		.out_row      (res.out_row),
		.inside_res   (res.inside_res),
		.escape_count (res.escape_count),
		.final_norm   (res.final_norm)
	);
endmodule
`default_nettype wire

// ----- design/etfi_datapath.sv -----
// Iteration datapath: products, squares, update of z, norm and result register.
`timescale 1ns / 1ps
`default_nettype none
module etfi_datapath #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 28
) (
	input  wire                                  clk,
	input  etfi_pkg::etfi_cmd_t                  cmd,
	input  wire signed [COORD_BITS-1:0]          start_re,
	input  wire signed [COORD_BITS-1:0]          start_im,
	input  wire signed [COORD_BITS-1:0]          const_re,
	input  wire signed [COORD_BITS-1:0]          const_im,
	input  wire [etfi_pkg::PIX_BITS-1:0]         pixel_col,
	input  wire [etfi_pkg::PIX_BITS-1:0]         pixel_row,
	input  wire [etfi_pkg::ESC_BITS-1:0]         escape_norm,
	output etfi_pkg::etfi_status_t               status,
	output logic [etfi_pkg::PIX_BITS-1:0]        out_col,
	output logic [etfi_pkg::PIX_BITS-1:0]        out_row,
	output logic                                 inside_res,
	output logic [etfi_pkg::ITER_BITS-1:0]       escape_count,
	output logic [etfi_pkg::NORM_BITS-1:0]       final_norm
);
	import etfi_pkg::*;

	localparam int PW = 2 * COORD_BITS;
	localparam int SW = PW + 2;
	localparam int NW = PW + 1 + NORM_FRAC;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_BITS+1){1'b0}},
		{(COORD_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_BITS+1){1'b1}},
		{(COORD_BITS-1){1'b0}}};

	logic signed [COORD_BITS-1:0] zr_q, zi_q, cr_q, ci_q;
	logic [PIX_BITS-1:0]          col_q, row_q;
	logic signed [PW-1:0]         p_rr_q, p_ii_q, p_ri_q;
	logic [NORM_BITS-1:0]         norm_q;

	logic signed [PW-1:0]         sq_re, sq_im, cross_term;
	logic signed [SW-1:0]         re_sum, im_sum;
	logic signed [COORD_BITS-1:0] zr_next, zi_next;
	logic [NW-1:0]                n_sum, n_scaled;
	logic [NORM_BITS-1:0]         norm_sat;

	always_comb begin
		sq_re      = p_rr_q >>> FRACTION_BITS;
		sq_im      = p_ii_q >>> FRACTION_BITS;
		cross_term = p_ri_q >>> (FRACTION_BITS - 1);
		re_sum     = SW'(sq_re) - SW'(sq_im) + SW'(cr_q);
		im_sum     = SW'(cross_term) + SW'(ci_q);

		priority if (re_sum > SAT_HI) begin
			zr_next = SAT_HI[COORD_BITS-1:0];
		end else if (re_sum < SAT_LO) begin
			zr_next = SAT_LO[COORD_BITS-1:0];
		end else begin
			zr_next = re_sum[COORD_BITS-1:0];
		end

		priority if (im_sum > SAT_HI) begin
			zi_next = SAT_HI[COORD_BITS-1:0];
		end else if (im_sum < SAT_LO) begin
			zi_next = SAT_LO[COORD_BITS-1:0];
		end else begin
			zi_next = im_sum[COORD_BITS-1:0];
		end

		// squares are never negative, so plain unsigned scaling floors correctly
		n_sum    = NW'($unsigned(sq_re)) + NW'($unsigned(sq_im));
		n_scaled = (n_sum << NORM_FRAC) >> FRACTION_BITS;
		norm_sat = (|n_scaled[NW-1:NORM_BITS]) ? {NORM_BITS{1'b1}}
			: n_scaled[NORM_BITS-1:0];
		status.escape = !(norm_sat < NORM_BITS'(escape_norm));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q  <= start_re;
			zi_q  <= start_im;
			cr_q  <= const_re;
			ci_q  <= const_im;
			col_q <= pixel_col;
			row_q <= pixel_row;
		end else if (cmd.eval) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
		end
		if (cmd.mul) begin
			p_rr_q <= PW'(zr_q) * PW'(zr_q);
			p_ii_q <= PW'(zi_q) * PW'(zi_q);
			p_ri_q <= PW'(zr_q) * PW'(zi_q);
		end
		if (cmd.eval) begin
			norm_q <= norm_sat;
		end
		if (cmd.out_load) begin
			out_col      <= col_q;
			out_row      <= row_q;
			inside_res   <= cmd.out_inside;
			escape_count <= cmd.out_count;
			final_norm   <= norm_q;
		end
	end
endmodule
`default_nettype wire

// ----- design/etfi_ctrl.sv -----
// Sequencer: job intake, iteration count, escape decision and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module etfi_ctrl (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  wire                              out_ready,
	input  wire [etfi_pkg::ITER_BITS-1:0]    max_iterations,
	input  etfi_pkg::etfi_status_t           status,
	output etfi_pkg::etfi_cmd_t              cmd
);
	import etfi_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic                 first_q;
	logic                 inside_q;
	logic                 out_valid_q;
	logic [ITER_BITS-1:0] n_q;
	logic [ITER_BITS-1:0] limit_q;
	logic                 last_iter;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign last_iter = ({1'b0, n_q} + 17'd1) == {1'b0, limit_q};

	always_comb begin
		cmd.load       = in_ready && in_valid;
		cmd.mul        = (state_q == ST_MUL);
		cmd.eval       = (state_q == ST_EVAL);
		cmd.out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
		cmd.out_inside = inside_q;
		cmd.out_count  = n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			limit_q     <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						limit_q <= max_iterations;
						n_q     <= '0;
						first_q <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// first pass only forms |z0|^2 and z1, no escape test
					priority if (first_q) begin
						first_q <= 1'b0;
						if (limit_q == '0) begin
							inside_q <= 1'b1;
							state_q  <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end else if (status.escape) begin
						inside_q <= 1'b0;
						state_q  <= ST_FIN;
					end else if (last_iter) begin
						inside_q <= 1'b1;
						n_q      <= limit_q;
						state_q  <= ST_FIN;
					end else begin
						n_q     <= n_q + 16'd1;
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
